>>> rtl/dsit_pkg.sv
`timescale 1ns / 1ps
// Package for the descending sorted insert table.
// Holds the request mode codes and the score width; depends on nothing.
package dsit_pkg;

  localparam int SCORE_W = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

endpackage

>>> rtl/dsit_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the entry store of the sorted table.
module dsit_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/descending_sorted_insert_table.sv
`timescale 1ns / 1ps
// Descending sorted insert table: up to DEPTH (score, tag) entries kept best first.
// Steps: an insert walks SCAN upwards from the bottom entry (skipped on an empty table),
// then PLACE and DONE; a read goes through READ and DONE; a clear goes straight to DONE.
// One request at a time: in_stall stays high from acceptance until the result enters the output register.
// Reset (rst_n, synchronous, active low) empties the table and drops any pending result;
// the entry RAM itself is not cleared, only entries at ranks below the fill count are ever used.
module descending_sorted_insert_table
  import dsit_pkg::*;
#(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_mode,
  input  logic signed [SCORE_W-1:0]        in_new_score,
  input  logic [TAG_BITS-1:0]              in_new_tag,
  input  logic [$clog2(DEPTH)-1:0]         in_read_rank,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [$clog2(DEPTH+1)-1:0]       out_position,
  output logic signed [SCORE_W-1:0]        out_entry_score,
  output logic [TAG_BITS-1:0]              out_entry_tag,
  output logic                             out_entry_valid,
  output logic [$clog2(DEPTH+1)-1:0]       out_entries_held,
  output logic                             out_pushed_out
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = SCORE_W + TAG_BITS;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // SCAN walks upwards from the last held entry, moving each lower entry down by
  // one rank, until it meets an entry whose score is not below the new one.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_READ,
    ST_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [CNT_W-1:0]          pos_r, pos_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic [TAG_BITS-1:0]       tag_r, tag_nxt;
  logic [IDX_W-1:0]          rank_r, rank_nxt;

  // finished result, waiting for the output register
  logic [CNT_W-1:0]          res_pos_r, res_pos_nxt;
  logic signed [SCORE_W-1:0] res_score_r, res_score_nxt;
  logic [TAG_BITS-1:0]       res_tag_r, res_tag_nxt;
  logic                      res_valid_r, res_valid_nxt;
  logic [CNT_W-1:0]          res_held_r, res_held_nxt;
  logic                      res_pushed_r, res_pushed_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]          out_pos_r, out_pos_nxt;
  logic signed [SCORE_W-1:0] out_score_r, out_score_nxt;
  logic [TAG_BITS-1:0]       out_tag_r, out_tag_nxt;
  logic                      out_evalid_r, out_evalid_nxt;
  logic [CNT_W-1:0]          out_held_r, out_held_nxt;
  logic                      out_pushed_r, out_pushed_nxt;

  // entry RAM port signals
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [ENT_W-1:0]          wr_data;
  logic [IDX_W-1:0]          rd_addr;
  logic [ENT_W-1:0]          rd_data;

  logic signed [SCORE_W-1:0] ent_score;
  logic [CNT_W-1:0]          fill_dec;
  logic [CNT_W-1:0]          idx_inc;

  // entry layout: score in the upper bits, tag below
  dsit_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ent_score = rd_data[ENT_W-1 -: SCORE_W];
  assign fill_dec  = fill_r - 1'b1;
  assign idx_inc   = CNT_W'(idx_r) + 1'b1;

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_position     = out_pos_r;
  assign out_entry_score  = out_score_r;
  assign out_entry_tag    = out_tag_r;
  assign out_entry_valid  = out_evalid_r;
  assign out_entries_held = out_held_r;
  assign out_pushed_out   = out_pushed_r;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    score_nxt      = score_r;
    tag_nxt        = tag_r;
    rank_nxt       = rank_r;
    res_pos_nxt    = res_pos_r;
    res_score_nxt  = res_score_r;
    res_tag_nxt    = res_tag_r;
    res_valid_nxt  = res_valid_r;
    res_held_nxt   = res_held_r;
    res_pushed_nxt = res_pushed_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_pos_nxt    = out_pos_r;
    out_score_nxt  = out_score_r;
    out_tag_nxt    = out_tag_r;
    out_evalid_nxt = out_evalid_r;
    out_held_nxt   = out_held_r;
    out_pushed_nxt = out_pushed_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = {score_r, tag_r};
    rd_addr        = idx_r;

    case (state_r)
      ST_IDLE: begin
        // read address goes out with the request so data is ready next cycle
        if (in_mode == MODE_READ) begin
          rd_addr = in_read_rank;
        end else begin
          rd_addr = fill_dec[IDX_W-1:0];
        end
        if (in_valid) begin
          score_nxt      = in_new_score;
          tag_nxt        = in_new_tag;
          rank_nxt       = in_read_rank;
          idx_nxt        = fill_dec[IDX_W-1:0];
          res_pos_nxt    = '0;
          res_score_nxt  = '0;
          res_tag_nxt    = '0;
          res_valid_nxt  = 1'b0;
          res_held_nxt   = fill_r;
          res_pushed_nxt = 1'b0;
          case (in_mode)
            MODE_INSERT: begin
              if (fill_r == '0) begin
                pos_nxt   = '0;
                state_nxt = ST_PLACE;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            MODE_READ: begin
              state_nxt = ST_READ;
            end
            MODE_CLEAR: begin
              fill_nxt     = '0;
              res_held_nxt = '0;
              state_nxt    = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        rd_addr = idx_r - 1'b1;
        if (score_r > ent_score) begin
          // entry ranks below the new one: move it down, lost off the end when full
          if (idx_inc < DEPTH_C) begin
            wr_en   = 1'b1;
            wr_addr = idx_inc[IDX_W-1:0];
            wr_data = rd_data;
          end
          if (idx_r == '0) begin
            pos_nxt   = '0;
            state_nxt = ST_PLACE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end else begin
          pos_nxt   = idx_inc;
          state_nxt = ST_PLACE;
        end
      end

      ST_PLACE: begin
        res_pos_nxt    = pos_r;
        res_pushed_nxt = (fill_r == DEPTH_C);
        if (pos_r < DEPTH_C) begin
          wr_en   = 1'b1;
          wr_addr = pos_r[IDX_W-1:0];
          if (fill_r != DEPTH_C) begin
            fill_nxt = fill_r + 1'b1;
          end
        end
        res_held_nxt = fill_nxt;
        state_nxt    = ST_DONE;
      end

      ST_READ: begin
        if (CNT_W'(rank_r) < fill_r) begin
          res_score_nxt = ent_score;
          res_tag_nxt   = rd_data[TAG_BITS-1:0];
          res_valid_nxt = 1'b1;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_pos_nxt    = res_pos_r;
          out_score_nxt  = res_score_r;
          out_tag_nxt    = res_tag_r;
          out_evalid_nxt = res_valid_r;
          out_held_nxt   = res_held_r;
          out_pushed_nxt = res_pushed_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    score_r      <= score_nxt;
    tag_r        <= tag_nxt;
    rank_r       <= rank_nxt;
    res_pos_r    <= res_pos_nxt;
    res_score_r  <= res_score_nxt;
    res_tag_r    <= res_tag_nxt;
    res_valid_r  <= res_valid_nxt;
    res_held_r   <= res_held_nxt;
    res_pushed_r <= res_pushed_nxt;
    out_pos_r    <= out_pos_nxt;
    out_score_r  <= out_score_nxt;
    out_tag_r    <= out_tag_nxt;
    out_evalid_r <= out_evalid_nxt;
    out_held_r   <= out_held_nxt;
    out_pushed_r <= out_pushed_nxt;
  end

endmodule
